@@ hw/rtl/note_off_and_control_ramp_scheduler_core_assert.svh @@
// Assertion macros for the ramp scheduler core
`ifndef NOTE_OFF_AND_CONTROL_RAMP_SCHEDULER_CORE_ASSERT_SVH
`define NOTE_OFF_AND_CONTROL_RAMP_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NOCRS_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nocrs assertion failed");
// next-cycle implication
`define NOCRS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nocrs assertion failed");
`else
`define NOCRS_ASSERT_NOW(name, clk, rst, ante, cons)
`define NOCRS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/nocrs_pkg.sv @@
package nocrs_pkg;
  localparam int NOTE_SLOTS  = 16;
  localparam int CTRL_SLOTS  = 8;
  localparam int QUEUE_DEPTH = NOTE_SLOTS + CTRL_SLOTS;

  localparam int NOTE_CNT_W = $clog2(NOTE_SLOTS + 1);
  localparam int CTRL_CNT_W = $clog2(CTRL_SLOTS + 1);
  localparam int NOTE_IDX_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
  localparam int CTRL_IDX_W = (CTRL_SLOTS > 1) ? $clog2(CTRL_SLOTS) : 1;
  localparam int WALK_W     = (NOTE_CNT_W > CTRL_CNT_W) ? NOTE_CNT_W : CTRL_CNT_W;
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // ramp arithmetic widths
  localparam int DELTA_W = 24;
  localparam int MAG_W   = 33;
  localparam int PROD_W  = MAG_W + DELTA_W;
  localparam int QUOT_W  = MAG_W;
  localparam int DCNT_W  = $clog2(PROD_W + 1);

  // commands
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON = 2'd1;
  localparam logic [1:0] CMD_CTRL    = 2'd2;
  localparam logic [1:0] CMD_FLUSH   = 2'd3;

  // message kinds
  localparam logic [1:0] KIND_NOTE     = 2'd0;
  localparam logic [1:0] KIND_CTRL     = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] key;
    logic [6:0]  vel;
    logic [31:0] value;
  } msg_t;
endpackage

@@ hw/rtl/nocrs_divider.sv @@
module nocrs_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nocrs_pkg::PROD_W-1:0]  dividend,
  input  logic [31:0]                   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [nocrs_pkg::QUOT_W-1:0]  quotient
);
  import nocrs_pkg::*;

  logic [PROD_W-1:0] q;
  logic [31:0]       r;
  logic [DCNT_W-1:0] cnt;
  logic [32:0]       trial;
  logic [32:0]       diffv;
  logic              ge;

  // one restoring step per cycle
  always_comb begin
    trial = {r, q[PROD_W-1]};
    diffv = trial - {1'b0, divisor};
    ge    = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= dividend;
        r    <= '0;
        cnt  <= DCNT_W'(PROD_W);
        busy <= 1'b1;
      end else if (busy) begin
        q   <= {q[PROD_W-2:0], ge};
        r   <= ge ? diffv[31:0] : trial[31:0];
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q[QUOT_W-1:0];
endmodule

@@ hw/rtl/note_off_and_control_ramp_scheduler_core.sv @@
// Note-off and control ramp scheduler.
// Input channel (in_valid / in_stall) carries one command: tick, note on,
// control event or flush. in_stall is high whenever a command is in work.
// Output channel (out_valid / out_stall) carries the messages a command
// causes, in order; last_result marks the final one and still_pending tells
// whether any note or control stays stored after the command.
// Note on and table overflow go to the drain state, and their message is
// registered on the output from there. A tick walks the note table one note
// at a time, then the control table; a control that takes a partial ramp
// step goes through setup, divider start, 57 bit-serial divider steps and a
// finishing step that stores the value. Messages are buffered and then
// drained one per cycle while the receiver takes them.
// A stalled output holds its message; the block waits and drops nothing.
// Reset empties both tables and the message buffer.
module note_off_and_control_ramp_scheduler_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [15:0] item_key,
  input  logic [6:0]  note_velocity,
  input  logic [31:0] item_duration,
  input  logic signed [31:0] start_value,
  input  logic signed [31:0] target_value,
  input  logic [23:0] tick_delta,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  message_kind,
  output logic [15:0] out_key,
  output logic [6:0]  out_velocity,
  output logic signed [31:0] out_value,
  output logic        still_pending,
  output logic        last_result
);
  import nocrs_pkg::*;
`include "note_off_and_control_ramp_scheduler_core_assert.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NOTE  = 3'd1;
  localparam logic [2:0] ST_CTRL  = 3'd2;
  localparam logic [2:0] ST_DIVS  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;
  localparam logic [2:0] ST_DRAIN = 3'd6;

  logic [2:0] state;

  // tables
  logic [15:0] n_key [NOTE_SLOTS];
  logic [31:0] n_rem [NOTE_SLOTS];
  logic [NOTE_CNT_W-1:0] note_count;
  logic [15:0] c_key   [CTRL_SLOTS];
  logic [31:0] c_cur   [CTRL_SLOTS];
  logic [31:0] c_goal  [CTRL_SLOTS];
  logic [31:0] c_rem   [CTRL_SLOTS];
  logic        c_first [CTRL_SLOTS];
  logic [CTRL_CNT_W-1:0] ctrl_count;

  // message buffer
  msg_t        queue [QUEUE_DEPTH];
  logic [QCNT_W-1:0] qn;
  logic [QCNT_W-1:0] rd;

  logic [WALK_W-1:0] i;
  logic [WALK_W-1:0] w;
  logic [DELTA_W-1:0] delta_r;
  logic [PROD_W-1:0]  prod;
  logic               neg;

  logic [31:0] delta32;
  logic [NOTE_IDX_W-1:0] ni;
  logic [CTRL_IDX_W-1:0] ci;
  logic [31:0] cur;
  logic [31:0] goal;
  logic [31:0] crem;
  logic        cfirst;
  logic [32:0] diff;
  logic [MAG_W-1:0] mag;
  logic        slow;
  logic [32:0] step;
  logic [32:0] sum;
  logic [31:0] fin_value;
  logic [31:0] fin_rem;
  logic        ctrl_fin;
  logic        out_free;

  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [QUOT_W-1:0] div_q;

  assign in_stall  = (state != ST_IDLE);
  assign div_start = (state == ST_DIVS);
  assign out_free  = !out_valid || !out_stall;

  nocrs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (crem),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // current control entry and its next value
  always_comb begin
    delta32 = {8'd0, delta_r};
    ni      = i[NOTE_IDX_W-1:0];
    ci      = i[CTRL_IDX_W-1:0];
    cur     = c_cur[ci];
    goal    = c_goal[ci];
    crem    = c_rem[ci];
    cfirst  = c_first[ci];
    diff    = {goal[31], goal} - {cur[31], cur};
    mag     = diff[32] ? -diff : diff;
    slow    = cfirst && (delta32 < crem);
    step    = neg ? -div_q : div_q;
    sum     = {cur[31], cur} + step;
    if (!cfirst) begin
      fin_value = cur;
      fin_rem   = crem;
    end else if (!slow) begin
      fin_value = goal;
      fin_rem   = '0;
    end else begin
      fin_value = sum[31:0];
      fin_rem   = crem - delta32;
    end
    ctrl_fin = ((state == ST_CTRL) && (i != WALK_W'(ctrl_count)) && !slow) ||
               ((state == ST_DIV) && div_done);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      note_count <= '0;
      ctrl_count <= '0;
      qn         <= '0;
      rd         <= '0;
      i          <= '0;
      w          <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            delta_r <= tick_delta;
            i       <= '0;
            w       <= '0;
            qn      <= '0;
            rd      <= '0;
            case (command)
              CMD_TICK: state <= ST_NOTE;
              CMD_NOTE_ON: begin
                if (note_count >= NOTE_CNT_W'(NOTE_SLOTS)) begin
                  queue[0] <= '{KIND_OVERFLOW, item_key, 7'd0, 32'd0};
                end else begin
                  n_key[note_count[NOTE_IDX_W-1:0]] <= item_key;
                  n_rem[note_count[NOTE_IDX_W-1:0]] <= item_duration;
                  note_count <= note_count + 1'b1;
                  queue[0] <= '{KIND_NOTE, item_key, note_velocity, 32'd0};
                end
                qn    <= QCNT_W'(1);
                state <= ST_DRAIN;
              end
              CMD_CTRL: begin
                if (ctrl_count >= CTRL_CNT_W'(CTRL_SLOTS)) begin
                  queue[0] <= '{KIND_OVERFLOW, item_key, 7'd0, 32'd0};
                  qn       <= QCNT_W'(1);
                end else begin
                  c_key[ctrl_count[CTRL_IDX_W-1:0]]   <= item_key;
                  c_cur[ctrl_count[CTRL_IDX_W-1:0]]   <= start_value;
                  c_goal[ctrl_count[CTRL_IDX_W-1:0]]  <= target_value;
                  c_rem[ctrl_count[CTRL_IDX_W-1:0]]   <= item_duration;
                  c_first[ctrl_count[CTRL_IDX_W-1:0]] <= 1'b0;
                  ctrl_count <= ctrl_count + 1'b1;
                end
                state <= ST_DRAIN;
              end
              default: state <= ST_FLUSH;
            endcase
          end
        end
        // note walk: expire or count down, compacting in place
        ST_NOTE: begin
          if (i == WALK_W'(note_count)) begin
            note_count <= w[NOTE_CNT_W-1:0];
            i          <= '0;
            w          <= '0;
            state      <= ST_CTRL;
          end else begin
            if (n_rem[ni] <= delta32) begin
              queue[qn[QIDX_W-1:0]] <= '{KIND_NOTE, n_key[ni], 7'd0, 32'd0};
              qn <= qn + 1'b1;
            end else begin
              n_key[w[NOTE_IDX_W-1:0]] <= n_key[ni];
              n_rem[w[NOTE_IDX_W-1:0]] <= n_rem[ni] - delta32;
              w <= w + 1'b1;
            end
            i <= i + 1'b1;
          end
        end
        ST_CTRL: begin
          if (i == WALK_W'(ctrl_count)) begin
            ctrl_count <= w[CTRL_CNT_W-1:0];
            state      <= ST_DRAIN;
          end else if (slow) begin
            prod  <= PROD_W'(mag) * PROD_W'(delta_r);
            neg   <= diff[32];
            state <= ST_DIVS;
          end
        end
        ST_DIVS: state <= ST_DIV;
        ST_DIV: begin
          if (div_done) state <= ST_CTRL;
        end
        ST_FLUSH: begin
          if (i == WALK_W'(note_count)) begin
            note_count <= '0;
            ctrl_count <= '0;
            state      <= ST_DRAIN;
          end else begin
            queue[qn[QIDX_W-1:0]] <= '{KIND_NOTE, n_key[ni], 7'd0, 32'd0};
            qn <= qn + 1'b1;
            i  <= i + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (rd == qn) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            rd <= rd + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // finish one control entry: send it, keep it unless expired
      if (ctrl_fin) begin
        queue[qn[QIDX_W-1:0]] <= '{KIND_CTRL, c_key[ci], 7'd0, fin_value};
        qn <= qn + 1'b1;
        if (fin_rem != 32'd0) begin
          c_key[w[CTRL_IDX_W-1:0]]   <= c_key[ci];
          c_cur[w[CTRL_IDX_W-1:0]]   <= fin_value;
          c_goal[w[CTRL_IDX_W-1:0]]  <= goal;
          c_rem[w[CTRL_IDX_W-1:0]]   <= fin_rem;
          c_first[w[CTRL_IDX_W-1:0]] <= 1'b1;
          w <= w + 1'b1;
        end
        i <= i + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DRAIN && rd != qn && out_free) begin
      out_valid     <= 1'b1;
      message_kind  <= queue[rd[QIDX_W-1:0]].kind;
      out_key       <= queue[rd[QIDX_W-1:0]].key;
      out_velocity  <= queue[rd[QIDX_W-1:0]].vel;
      out_value     <= queue[rd[QIDX_W-1:0]].value;
      still_pending <= (note_count != '0) || (ctrl_count != '0);
      last_result   <= (rd + 1'b1 == qn);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `NOCRS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && !in_stall, state != ST_IDLE)
  `NOCRS_ASSERT_NOW(a_div_done_in_div, clk, rst, div_done, state == ST_DIV)
  `NOCRS_ASSERT_NOW(a_div_start_idle, clk, rst, div_start, !div_busy)
  `NOCRS_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, qn <= QCNT_W'(QUEUE_DEPTH))
endmodule

@@ verif/tb_note_off_and_control_ramp_scheduler_core.sv @@
`timescale 1ns / 1ps

module tb_note_off_and_control_ramp_scheduler_core;
  import nocrs_pkg::*;

  localparam int IDLE_LIMIT  = 40000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] key;
    logic [6:0]  vel;
    logic [31:0] dur;
    logic [31:0] start;
    logic [31:0] target;
    logic [23:0] delta;
  } sched_cmd_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] key;
    logic [6:0]  vel;
    logic [31:0] value;
    logic        pend;
    logic        last;
  } sched_msg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0]  command = CMD_TICK;
  logic [15:0] item_key = '0;
  logic [6:0]  note_velocity = '0;
  logic [31:0] item_duration = '0;
  logic signed [31:0] start_value = '0;
  logic signed [31:0] target_value = '0;
  logic [23:0] tick_delta = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0]  message_kind;
  logic [15:0] out_key;
  logic [6:0]  out_velocity;
  logic signed [31:0] out_value;
  logic still_pending;
  logic last_result;

  note_off_and_control_ramp_scheduler_core dut (.*);

  // shadow tables
  logic [15:0] note_id [NOTE_SLOTS];
  logic [31:0] note_left [NOTE_SLOTS];
  int          notes_held = 0;
  logic [15:0] ctrl_id [CTRL_SLOTS];
  longint      ctrl_now [CTRL_SLOTS];
  longint      ctrl_aim [CTRL_SLOTS];
  logic [31:0] ctrl_left [CTRL_SLOTS];
  bit          ctrl_sent [CTRL_SLOTS];
  int          ctrls_held = 0;

  sched_cmd_t pending_cmds[$];
  sched_msg_t owed_msgs[$];
  int errors = 0;
  int cmds_taken = 0, msgs_seen = 0, overflows_seen = 0, ramps_seen = 0;
  int idle_cycles = 0;
  bit taken = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic sched_msg_t make_msg(logic [1:0] kind, logic [15:0] key,
                                          logic [6:0] vel, logic [31:0] value);
    sched_msg_t m;
    m.kind = kind; m.key = key; m.vel = vel; m.value = value;
    m.pend = 1'b0; m.last = 1'b0;
    return m;
  endfunction

  // expected messages of one accepted command
  task automatic schedule_step(sched_cmd_t c);
    sched_msg_t outq[$];
    int w;
    longint diff;
    longint unsigned mag, stepm;
    if (c.cmd == CMD_TICK) begin
      w = 0;
      for (int i = 0; i < notes_held; i++) begin
        if (note_left[i] <= {8'd0, c.delta}) begin
          outq = {outq, make_msg(KIND_NOTE, note_id[i], 7'd0, 32'd0)};
        end else begin
          note_id[w] = note_id[i];
          note_left[w] = note_left[i] - c.delta;
          w++;
        end
      end
      notes_held = w;
      w = 0;
      for (int i = 0; i < ctrls_held; i++) begin
        if (!ctrl_sent[i]) begin
          ctrl_sent[i] = 1'b1;
        end else if ({8'd0, c.delta} >= ctrl_left[i]) begin
          ctrl_now[i] = ctrl_aim[i];
          ctrl_left[i] = 0;
        end else begin
          diff = ctrl_aim[i] - ctrl_now[i];
          mag = (diff < 0) ? -diff : diff;
          stepm = mag * c.delta / ctrl_left[i];
          ctrl_now[i] += (diff < 0) ? -longint'(stepm) : longint'(stepm);
          ctrl_left[i] -= c.delta;
        end
        outq = {outq, make_msg(KIND_CTRL, ctrl_id[i], 7'd0, ctrl_now[i][31:0])};
        if (ctrl_left[i] != 0) begin
          ctrl_id[w] = ctrl_id[i]; ctrl_now[w] = ctrl_now[i];
          ctrl_aim[w] = ctrl_aim[i]; ctrl_left[w] = ctrl_left[i];
          ctrl_sent[w] = ctrl_sent[i];
          w++;
        end
      end
      ctrls_held = w;
    end else if (c.cmd == CMD_NOTE_ON) begin
      if (notes_held >= NOTE_SLOTS) begin
        outq = {outq, make_msg(KIND_OVERFLOW, c.key, 7'd0, 32'd0)};
      end else begin
        note_id[notes_held] = c.key;
        note_left[notes_held] = c.dur;
        notes_held++;
        outq = {outq, make_msg(KIND_NOTE, c.key, c.vel, 32'd0)};
      end
    end else if (c.cmd == CMD_CTRL) begin
      if (ctrls_held >= CTRL_SLOTS) begin
        outq = {outq, make_msg(KIND_OVERFLOW, c.key, 7'd0, 32'd0)};
      end else begin
        ctrl_id[ctrls_held] = c.key;
        ctrl_now[ctrls_held] = longint'(signed'(c.start));
        ctrl_aim[ctrls_held] = longint'(signed'(c.target));
        ctrl_left[ctrls_held] = c.dur;
        ctrl_sent[ctrls_held] = 1'b0;
        ctrls_held++;
      end
    end else begin
      for (int i = 0; i < notes_held; i++)
        outq = {outq, make_msg(KIND_NOTE, note_id[i], 7'd0, 32'd0)};
      notes_held = 0;
      ctrls_held = 0;
    end
    foreach (outq[k]) begin
      outq[k].pend = (notes_held != 0) || (ctrls_held != 0);
      outq[k].last = (k == outq.size() - 1);
      owed_msgs = {owed_msgs, outq[k]};
    end
  endtask

  task automatic queue_cmd(logic [1:0] cmd, logic [15:0] key, logic [6:0] vel,
                           logic [31:0] dur, logic [31:0] sv, logic [31:0] tv,
                           logic [23:0] dl);
    sched_cmd_t c;
    c.cmd = cmd; c.key = key; c.vel = vel; c.dur = dur;
    c.start = sv; c.target = tv; c.delta = dl;
    pending_cmds = {pending_cmds, c};
  endtask

  // random note on / control event with mostly short durations
  task automatic queue_random(logic [1:0] cmd);
    logic [31:0] dur;
    dur = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 32'h0006_0000);
    queue_cmd(cmd, 16'($urandom()), 7'($urandom()), dur, $urandom(), $urandom(),
              24'($urandom()));
  endtask

  task automatic queue_tick();
    logic [23:0] dl;
    dl = ($urandom_range(0, 7) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 24'h02_0000));
    queue_cmd(CMD_TICK, 16'($urandom()), 7'($urandom()), $urandom(), $urandom(),
              $urandom(), dl);
  endtask

  // stimulus
  initial begin
    int made;
    int n;
    // directed: extremes, zero durations, landing, partial steps, flush
    queue_cmd(CMD_TICK, 16'h0, 7'h0, 32'h0, 32'h0, 32'h0, 24'h0);
    queue_cmd(CMD_NOTE_ON, 16'hFFFF, 7'h7F, 32'h0, 32'h0, 32'h0, 24'h0);
    queue_cmd(CMD_NOTE_ON, 16'h0000, 7'h00, 32'hFFFF_FFFF, 32'h0, 32'h0, 24'hFFFFFF);
    queue_cmd(CMD_NOTE_ON, 16'h1234, 7'h40, 32'h0001_0000, 32'h0, 32'h0, 24'h0);
    queue_cmd(CMD_CTRL, 16'hFFFF, 7'h7F, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 24'h0);
    queue_cmd(CMD_CTRL, 16'h0001, 7'h0, 32'h0004_0000, 32'h8000_0000, 32'h7FFF_FFFF, 24'h0);
    queue_cmd(CMD_CTRL, 16'h0002, 7'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 24'h0);
    queue_cmd(CMD_CTRL, 16'h0003, 7'h0, 32'h0000_0003, 32'h0001_0000, 32'hFFFF_0000, 24'h0);
    queue_cmd(CMD_TICK, 16'h0, 7'h0, 32'h0, 32'h0, 32'h0, 24'h00_0000);
    queue_cmd(CMD_TICK, 16'h0, 7'h0, 32'h0, 32'h0, 32'h0, 24'h00_0001);
    queue_cmd(CMD_TICK, 16'h0, 7'h0, 32'h0, 32'h0, 32'h0, 24'h01_0000);
    queue_cmd(CMD_TICK, 16'h0, 7'h0, 32'h0, 32'h0, 32'h0, 24'hFF_FFFF);
    queue_cmd(CMD_TICK, 16'h0, 7'h0, 32'h0, 32'h0, 32'h0, 24'h7F_FFFF);
    queue_cmd(CMD_TICK, 16'h0, 7'h0, 32'h0, 32'h0, 32'h0, 24'hFF_FFFF);
    queue_cmd(CMD_NOTE_ON, 16'h00AA, 7'h55, 32'h7FFF_0000, 32'h0, 32'h0, 24'h0);
    queue_cmd(CMD_CTRL, 16'h00BB, 7'h0, 32'h0010_0000, 32'h0, 32'h0100_0000, 24'h0);
    queue_cmd(CMD_FLUSH, 16'h0, 7'h0, 32'h0, 32'h0, 32'h0, 24'h0);
    queue_cmd(CMD_FLUSH, 16'h0, 7'h0, 32'h0, 32'h0, 32'h0, 24'h0);
    queue_cmd(CMD_TICK, 16'h0, 7'h0, 32'h0, 32'h0, 32'h0, 24'h00_1000);
    made = 0;
    // random phrases: a fill, a few ticks, sometimes a flush
    while (made < RANDOM_ITEMS) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        queue_random(($urandom_range(0, 2) == 0) ? CMD_CTRL : CMD_NOTE_ON);
        made++;
      end
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        queue_tick();
        made++;
      end
      if ($urandom_range(0, 5) == 0) begin
        queue_cmd(CMD_FLUSH, 16'($urandom()), 7'($urandom()), $urandom(), $urandom(),
                  $urandom(), 24'($urandom()));
        made++;
      end
    end
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (pending_cmds.size() == 0 && !in_valid && owed_msgs.size() == 0);
    repeat (700) @(posedge clk);
    $display("Covered %0d commands, %0d messages (%0d control, %0d overflow).",
             cmds_taken, msgs_seen, ramps_seen, overflows_seen);
    if (errors == 0 && owed_msgs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // command driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (!rst && !(in_valid && !taken)) begin
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        sched_cmd_t c;
        c = pending_cmds.pop_front();
        in_valid <= 1'b1;
        command <= c.cmd; item_key <= c.key; note_velocity <= c.vel;
        item_duration <= c.dur; start_value <= c.start;
        target_value <= c.target; tick_delta <= c.delta;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver stall pattern: free, random or heavy phases
  int stall_phase = 0, phase_left = 0;
  always @(negedge clk) begin
    if (phase_left == 0) begin
      stall_phase <= $urandom_range(0, 2);
      phase_left <= $urandom_range(20, 200);
      out_stall <= 1'b0;
    end else begin
      phase_left <= phase_left - 1;
      case (stall_phase)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // command transfer: predict
  always @(posedge clk) begin
    taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      sched_cmd_t c;
      c.cmd = command; c.key = item_key; c.vel = note_velocity;
      c.dur = item_duration; c.start = start_value;
      c.target = target_value; c.delta = tick_delta;
      schedule_step(c);
      cmds_taken++;
    end
  end

  // message transfer: check against oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      msgs_seen++;
      if (owed_msgs.size() == 0) begin
        $error("unexpected message kind=%0d key=%h", message_kind, out_key);
        errors++;
      end else begin
        sched_msg_t m;
        m = owed_msgs.pop_front();
        if (m.kind == KIND_OVERFLOW) overflows_seen++;
        if (m.kind == KIND_CTRL) ramps_seen++;
        if (message_kind !== m.kind) begin
          $error("message_kind: expected %0d, got %0d", m.kind, message_kind);
          errors++;
        end
        if (out_key !== m.key) begin
          $error("out_key: expected %h, got %h", m.key, out_key);
          errors++;
        end
        if (out_velocity !== m.vel) begin
          $error("out_velocity: expected %0d, got %0d", m.vel, out_velocity);
          errors++;
        end
        if (out_value !== m.value) begin
          $error("out_value: expected %h, got %h", m.value, out_value);
          errors++;
        end
        if (still_pending !== m.pend) begin
          $error("still_pending: expected %b, got %b", m.pend, still_pending);
          errors++;
        end
        if (last_result !== m.last) begin
          $error("last_result: expected %b, got %b", m.last, last_result);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
